[sv/framed_command_receiver_unit_defines.svh]
// Assertion macros used by the framed command receiver top-level RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FRAMED_COMMAND_RECEIVER_UNIT_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRCR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/frcr_pkg.sv]
// Shared types and constants of the framed command receiver.
// No dependencies; used by the front, queue, back and top-level modules.
`timescale 1ns / 1ps

package frcr_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_CHAR  = 3'd0;
    localparam logic [2:0] CFG_END_CHAR    = 3'd1;
    localparam logic [2:0] CFG_TIME_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_SPEED_LIMIT = 3'd3;
    localparam logic [2:0] CFG_PPR         = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TIME      = 2'd1;
    localparam logic [1:0] ST_SPEED     = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    // Command characters.
    localparam logic [7:0] CMD_GO      = 8'h67; // g
    localparam logic [7:0] CMD_HALT    = 8'h68; // h
    localparam logic [7:0] CMD_TIME    = 8'h74; // t
    localparam logic [7:0] CMD_SPEED   = 8'h73; // s
    localparam logic [7:0] CMD_RELOAD  = 8'h72; // r
    localparam logic [7:0] CMD_CONT    = 8'h63; // c
    localparam logic [7:0] CMD_DUMP    = 8'h64; // d

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // One parsed packet, handed from front to back.
    typedef struct packed {
        logic               malformed;
        logic [7:0]         command;
        logic signed [31:0] argument;
    } t_job;

    // Limits and scale taken from the configuration registers.
    typedef struct packed {
        logic [15:0] time_limit;
        logic [15:0] speed_limit;
        logic [15:0] ppr;
    } t_limits;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         command;
        logic signed [31:0] argument;
        logic               running;
        logic               start_run;
        logic [47:0]        rotation_pulses;
        logic               stop_run;
        logic               counter_load;
        logic [15:0]        counter_value;
        logic               dump_request;
    } t_result;

endpackage

[sv/frcr_front.sv]
// Packet framing and on-the-fly parser of the framed command receiver.
// Depends on frcr_pkg; pushes one t_job per closed packet into the queue.
`timescale 1ns / 1ps

module frcr_front #(
    parameter int RX_BUFFER_SIZE = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic [7:0]          i_start_char,
    input  logic [7:0]          i_end_char,
    output logic                o_push,
    output frcr_pkg::t_job      o_job
);

    localparam int POS_W = $clog2(RX_BUFFER_SIZE + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(RX_BUFFER_SIZE);
    localparam logic signed [35:0] ACC_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] ACC_MIN = -36'sh0_8000_0000;

    typedef enum logic [6:0] {
        PH_BEFORE_CMD = 7'b0000001,
        PH_AFTER_CMD  = 7'b0000010,
        PH_PLUS       = 7'b0000100,
        PH_POS_DIGITS = 7'b0001000,
        PH_DONE       = 7'b0010000,
        PH_MINUS      = 7'b0100000,
        PH_NEG_DIGITS = 7'b1000000
    } t_phase;

    logic               r_in_packet, n_in_packet;
    logic [POS_W-1:0]   r_pos, n_pos;
    t_phase             r_phase, n_phase;
    logic [7:0]         r_cmd, n_cmd;
    logic signed [31:0] r_param, n_param;

    logic               w_space;
    logic               w_digit;
    logic               w_first;
    logic               w_neg;
    logic signed [35:0] w_base;
    logic signed [35:0] w_times10;
    logic signed [35:0] w_sum;
    logic signed [31:0] w_acc;

    assign w_space = (i_rx_byte == 8'h20) || (i_rx_byte >= 8'h09 && i_rx_byte <= 8'h0D);
    assign w_digit = (i_rx_byte >= 8'h30) && (i_rx_byte <= 8'h39);

    // Decimal accumulate with saturation at the 32-bit signed limits.
    always_comb begin
        w_first   = (r_phase == PH_AFTER_CMD) || (r_phase == PH_PLUS) || (r_phase == PH_MINUS);
        w_neg     = (r_phase == PH_MINUS) || (r_phase == PH_NEG_DIGITS);
        w_base    = w_first ? 36'sd0 : 36'(r_param);
        w_times10 = (w_base <<< 3) + (w_base <<< 1);
        if (w_neg) begin
            w_sum = w_times10 - $signed({32'd0, i_rx_byte[3:0]});
        end else begin
            w_sum = w_times10 + $signed({32'd0, i_rx_byte[3:0]});
        end
        if (w_neg && w_sum < ACC_MIN) begin
            w_acc = 32'sh8000_0000;
        end else if (!w_neg && w_sum > ACC_MAX) begin
            w_acc = 32'sh7FFF_FFFF;
        end else begin
            w_acc = w_sum[31:0];
        end
    end

    always_comb begin
        n_in_packet = r_in_packet;
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_param     = r_param;
        o_push      = 1'b0;
        o_job.malformed = (r_pos >= POS_LIMIT) || (r_phase == PH_BEFORE_CMD);
        o_job.command   = r_cmd;
        o_job.argument  = r_param;
        if (i_accept) begin
            if (!r_in_packet) begin
                if (i_rx_byte == i_start_char) begin
                    n_in_packet = 1'b1;
                    n_pos       = POS_W'(1);
                    n_phase     = PH_BEFORE_CMD;
                end
            end else if (i_rx_byte != i_end_char) begin
                if (r_pos < POS_LIMIT) begin
                    n_pos = r_pos + POS_W'(1);
                    case (r_phase)
                        PH_BEFORE_CMD: begin
                            if (!w_space) begin
                                n_cmd   = i_rx_byte;
                                n_phase = PH_AFTER_CMD;
                            end
                        end
                        PH_AFTER_CMD: begin
                            if (w_space) begin
                                n_phase = PH_AFTER_CMD;
                            end else if (i_rx_byte == 8'h2B) begin
                                n_phase = PH_PLUS;
                            end else if (i_rx_byte == 8'h2D) begin
                                n_phase = PH_MINUS;
                            end else if (w_digit) begin
                                n_param = w_acc;
                                n_phase = PH_POS_DIGITS;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                        PH_PLUS, PH_MINUS: begin
                            if (w_digit) begin
                                n_param = w_acc;
                                n_phase = w_neg ? PH_NEG_DIGITS : PH_POS_DIGITS;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                        PH_POS_DIGITS, PH_NEG_DIGITS: begin
                            if (w_digit) begin
                                n_param = w_acc;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end else begin
                o_push      = 1'b1;
                n_in_packet = 1'b0;
                n_pos       = '0;
                n_phase     = PH_BEFORE_CMD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_pos       <= '0;
            r_phase     <= PH_BEFORE_CMD;
            r_cmd       <= '0;
            r_param     <= '0;
        end else begin
            r_in_packet <= n_in_packet;
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_param     <= n_param;
        end
    end

endmodule

[sv/frcr_queue.sv]
// Short command queue between the parser front and the command back.
// Depends on frcr_pkg for the job type and depth constants.
`timescale 1ns / 1ps

module frcr_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  frcr_pkg::t_job          i_job,
    input  logic                    i_pop,
    output frcr_pkg::t_job          o_job,
    output logic                    o_empty,
    output logic                    o_full
);

    frcr_pkg::t_job                       r_mem [frcr_pkg::QUEUE_DEPTH];
    logic [frcr_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [frcr_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [frcr_pkg::QUEUE_CNT_W-1:0]     r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == frcr_pkg::QUEUE_CNT_W'(frcr_pkg::QUEUE_DEPTH));
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/frcr_back.sv]
// Command executor: run state, speed and time settings, and pulse count.
// Depends on frcr_pkg; takes jobs from the queue and holds the result register.
`timescale 1ns / 1ps

module frcr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  frcr_pkg::t_job      i_job,
    input  logic                i_job_valid,
    output logic                o_pop,
    input  frcr_pkg::t_limits   i_limits,
    output frcr_pkg::t_result   o_result,
    output logic                o_valid,
    input  logic                i_ready
);

    // floor(x / 15) = (x * RECIP15) >> 34 for every x below 2^30.
    localparam logic [30:0] RECIP15 = 31'h4444_4445;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_QUOT  = 3'b010,
        S_PULSE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic                r_run, n_run;
    logic [15:0]         r_speed, n_speed;
    logic [15:0]         r_down, n_down;
    logic [15:0]         r_session, n_session;
    logic [31:0]         r_prod, n_prod;
    logic [26:0]         r_quot, n_quot;
    frcr_pkg::t_result   r_res, n_res;
    logic                r_valid, n_valid;

    logic [60:0]         w_recip;
    logic                w_in_range_time;
    logic                w_in_range_speed;

    assign w_recip = 61'(r_prod[31:2]) * 61'(RECIP15);
    assign w_in_range_time  = !i_job.argument[31] && (i_job.argument[30:16] == '0)
                              && (i_job.argument[15:0] < i_limits.time_limit);
    assign w_in_range_speed = !i_job.argument[31] && (i_job.argument[30:16] == '0)
                              && (i_job.argument[15:0] < i_limits.speed_limit);

    assign o_pop    = (r_state == S_IDLE) && (!r_valid || i_ready) && i_job_valid;
    assign o_result = r_res;
    assign o_valid  = r_valid;

    always_comb begin
        n_state   = r_state;
        n_run     = r_run;
        n_speed   = r_speed;
        n_down    = r_down;
        n_session = r_session;
        n_prod    = r_prod;
        n_quot    = r_quot;
        n_res     = r_res;
        n_valid   = r_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_res                 = '0;
                    n_res.status          = frcr_pkg::ST_OK;
                    n_res.command         = i_job.command;
                    n_res.argument        = i_job.argument;
                    n_valid               = 1'b1;
                    if (i_job.malformed) begin
                        n_res.status = frcr_pkg::ST_MALFORMED;
                    end else if (r_run) begin
                        if (i_job.command == frcr_pkg::CMD_HALT) begin
                            n_run          = 1'b0;
                            n_res.stop_run = 1'b1;
                        end
                    end else begin
                        case (i_job.command)
                            frcr_pkg::CMD_GO: begin
                                n_run           = 1'b1;
                                n_res.start_run = 1'b1;
                                n_prod          = {16'd0, i_limits.ppr} * {16'd0, r_speed};
                                n_valid         = 1'b0;
                                n_state         = S_QUOT;
                            end
                            frcr_pkg::CMD_TIME: begin
                                if (w_in_range_time) begin
                                    n_down              = i_job.argument[15:0];
                                    n_session           = i_job.argument[15:0];
                                    n_res.counter_load  = 1'b1;
                                    n_res.counter_value = i_job.argument[15:0];
                                end else begin
                                    n_res.status = frcr_pkg::ST_TIME;
                                end
                            end
                            frcr_pkg::CMD_RELOAD, frcr_pkg::CMD_CONT: begin
                                n_down              = r_session;
                                n_res.counter_load  = 1'b1;
                                n_res.counter_value = r_session;
                            end
                            frcr_pkg::CMD_SPEED: begin
                                if (w_in_range_speed) begin
                                    n_speed = i_job.argument[15:0];
                                end else begin
                                    n_res.status = frcr_pkg::ST_SPEED;
                                end
                            end
                            frcr_pkg::CMD_DUMP: begin
                                n_res.dump_request = 1'b1;
                            end
                            default: begin
                                n_res.status = frcr_pkg::ST_OK;
                            end
                        endcase
                    end
                    n_res.running = n_run;
                end
            end
            S_QUOT: begin
                n_quot  = w_recip[60:34];
                n_state = S_PULSE;
            end
            S_PULSE: begin
                n_res.rotation_pulses = 48'(r_quot) * 48'(r_down);
                n_valid               = 1'b1;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_quot <= n_quot;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_run     <= 1'b0;
            r_speed   <= '0;
            r_down    <= '0;
            r_session <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_run     <= n_run;
            r_speed   <= n_speed;
            r_down    <= n_down;
            r_session <= n_session;
            r_valid   <= n_valid;
        end
    end

endmodule

[sv/framed_command_receiver_unit.sv]
// Framed command receiver: takes received bytes one per transfer, frames and
// parses packets, and runs each closed packet's command, giving one result
// transfer per packet. The front accepts a byte in every cycle while its command
// queue (four packets deep) has room; bytes that do not close a packet never
// produce a result. The executor finishes a closed packet as it takes it from the
// queue, except a 'g' start command, which goes on in steps: pulses_per_rotation
// times speed, then the constant division by 60 done as a reciprocal multiply, then
// the multiply by the countdown time. The result register lets a new command start
// as soon as the previous result is taken. No clearing pass is needed after reset.
// Configuration writes take effect at once and should only be made while no packet
// is in flight.
// Depends on frcr_pkg, frcr_front, frcr_queue, frcr_back and the defines header.
`timescale 1ns / 1ps
`include "framed_command_receiver_unit_defines.svh"

module framed_command_receiver_unit #(
    parameter int RX_BUFFER_SIZE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // Byte input channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    // Result output channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [7:0]         o_command,
    output logic signed [31:0] o_argument,
    output logic               o_running,
    output logic               o_start_run,
    output logic [47:0]        o_rotation_pulses,
    output logic               o_stop_run,
    output logic               o_counter_load,
    output logic [15:0]        o_counter_value,
    output logic               o_dump_request
);

    // Configuration registers.
    logic [7:0]  r_start_char;
    logic [7:0]  r_end_char;
    logic [15:0] r_time_limit;
    logic [15:0] r_speed_limit;
    logic [15:0] r_ppr;

    frcr_pkg::t_limits w_limits;
    frcr_pkg::t_job    w_push_job;
    frcr_pkg::t_job    w_head_job;
    frcr_pkg::t_result w_result;
    logic              w_accept;
    logic              w_push;
    logic              w_pop;
    logic              w_q_empty;
    logic              w_q_full;

    // Terms used by the checks at the end of the module.
    logic              w_out_malformed;
    logic              w_out_start;
    logic              w_any_action;
    logic              w_fields_clean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char  <= 8'd60;
            r_end_char    <= 8'd62;
            r_time_limit  <= 16'd3600;
            r_speed_limit <= 16'd1000;
            r_ppr         <= 16'd200;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                frcr_pkg::CFG_START_CHAR:  r_start_char  <= i_cfg_data[7:0];
                frcr_pkg::CFG_END_CHAR:    r_end_char    <= i_cfg_data[7:0];
                frcr_pkg::CFG_TIME_LIMIT:  r_time_limit  <= i_cfg_data;
                frcr_pkg::CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                frcr_pkg::CFG_PPR:         r_ppr         <= i_cfg_data;
                default: begin
                    r_ppr <= r_ppr;
                end
            endcase
        end
    end

    assign w_limits.time_limit  = r_time_limit;
    assign w_limits.speed_limit = r_speed_limit;
    assign w_limits.ppr         = r_ppr;

    // The front only needs queue room when a byte closes a packet, but holding
    // every byte while the queue is full keeps the handshake simple.
    assign o_in_ready = !w_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    frcr_front #(
        .RX_BUFFER_SIZE (RX_BUFFER_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_rx_byte    (i_rx_byte),
        .i_start_char (r_start_char),
        .i_end_char   (r_end_char),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    frcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    frcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_job_valid (!w_q_empty),
        .o_pop       (w_pop),
        .i_limits    (w_limits),
        .o_result    (w_result),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready)
    );

    assign o_status          = w_result.status;
    assign o_command         = w_result.command;
    assign o_argument        = w_result.argument;
    assign o_running         = w_result.running;
    assign o_start_run       = w_result.start_run;
    assign o_rotation_pulses = w_result.rotation_pulses;
    assign o_stop_run        = w_result.stop_run;
    assign o_counter_load    = w_result.counter_load;
    assign o_counter_value   = w_result.counter_value;
    assign o_dump_request    = w_result.dump_request;

    assign w_out_malformed = o_out_valid && (o_status == frcr_pkg::ST_MALFORMED);
    assign w_out_start     = o_out_valid && o_start_run;
    assign w_any_action    = o_start_run || o_stop_run || o_counter_load || o_dump_request;
    assign w_fields_clean  = (o_start_run || (o_rotation_pulses == 48'd0))
                             && (o_counter_load || (o_counter_value == 16'd0));

    // A malformed packet never triggers any action.
    `FRCR_ASSERT_SAME(a_malformed_no_action, w_out_malformed, !w_any_action, "malformed action")
    // Starting and stopping a run are exclusive, and a start leaves the unit running.
    `FRCR_ASSERT_SAME(a_start_stop_excl, w_out_start, !o_stop_run && o_running, "bad start result")
    // Pulse count and countdown value are zero unless their strobe is set.
    `FRCR_ASSERT_SAME(a_zero_fields, o_out_valid, w_fields_clean, "unused result field not zero")
    // Taking a packet from the queue always leaves room for the next byte.
    `FRCR_ASSERT_NEXT(a_pop_frees_slot, w_pop, o_in_ready, "queue still full after a pop")

endmodule

[verif/tb_framed_command_receiver_unit.sv]
// Self-checking testbench for framed_command_receiver_unit: byte stream in, one result per packet.
// Predicts every result in SystemVerilog from the accepted bytes and checks each result transfer.
// Depends on frcr_pkg and the framed_command_receiver_unit RTL.
`timescale 1ns / 1ps

module tb_framed_command_receiver_unit;

    // The instance is built with this packet buffer size, and the predictor uses the same value.
    localparam int BUFFER_DEPTH    = 64;
    // A 'g' also passes the executor's quotient and pulse states besides the queue and result register; this is ample.
    localparam int TAIL_CYCLES     = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_BYTES     = 320;
    localparam int REPORT_LIMIT    = 10;

    // Characters the parser treats specially.
    localparam logic [7:0] CH_SPACE = 8'h20, CH_TAB = 8'h09, CH_CR = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30, CH_NINE = 8'h39;
    localparam logic [7:0] CH_PLUS = 8'h2B, CH_MINUS = 8'h2D;

    localparam longint ARG_MAX = 64'sd2147483647;
    localparam longint ARG_MIN = -64'sd2147483647 - 64'sd1;

    // Parser progress through the packet body.
    typedef enum logic [2:0] {
        SEEK_CMD, AFTER_CMD, SAW_PLUS, POS_DIGITS, ARG_DONE, SAW_MINUS, NEG_DIGITS
    } t_parse_state;

    // DUT inputs. Each has a known value from time zero.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_index   = frcr_pkg::CFG_START_CHAR;
    logic [15:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic [7:0]  rx_byte     = '0;
    logic        out_ready   = 1'b0;

    // DUT outputs.
    logic               in_ready;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [7:0]         o_command;
    logic signed [31:0] o_argument;
    logic               o_running;
    logic               o_start_run;
    logic [47:0]        o_rotation_pulses;
    logic               o_stop_run;
    logic               o_counter_load;
    logic [15:0]        o_counter_value;
    logic               o_dump_request;

    // Bytes waiting to be offered, and results the predictor says must come out, oldest first.
    logic [7:0]        byte_q [$];
    frcr_pkg::t_result result_q [$];

    // Traffic shaping; the percentages and hold_arm change only between phases.
    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    bit  hold_arm        = 1'b0;
    logic hold_active    = 1'b0;

    // Predictor copy of the configuration registers, at their reset values.
    logic [7:0]  cfg_start       = 8'd60;
    logic [7:0]  cfg_end         = 8'd62;
    logic [15:0] cfg_time_limit  = 16'd3600;
    logic [15:0] cfg_speed_limit = 16'd1000;
    logic [15:0] cfg_ppr         = 16'd200;

    // Predictor copy of the framing, parsing and motor state.
    bit                 frame_open    = 1'b0;
    int                 frame_len     = 0;
    t_parse_state       parse_state   = SEEK_CMD;
    logic [7:0]         cmd_char      = '0;
    logic signed [31:0] arg_value     = '0;
    bit                 motor_running = 1'b0;
    logic [15:0]        speed_rpm     = '0;
    logic [15:0]        down_time     = '0;
    logic [15:0]        session_time  = '0;

    // Bookkeeping.
    int mismatches     = 0;
    int bytes_accepted = 0;
    int results_seen   = 0;
    int framed_bytes   = 0;
    int settings_used  = 1;
    int runs_started   = 0;
    int runs_halted    = 0;
    int status_count [4] = '{0, 0, 0, 0};

    framed_command_receiver_unit #(
        .RX_BUFFER_SIZE(BUFFER_DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_status         (o_status),
        .o_command        (o_command),
        .o_argument       (o_argument),
        .o_running        (o_running),
        .o_start_run      (o_start_run),
        .o_rotation_pulses(o_rotation_pulses),
        .o_stop_run       (o_stop_run),
        .o_counter_load   (o_counter_load),
        .o_counter_value  (o_counter_value),
        .o_dump_request   (o_dump_request)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Command predictor
    // ------------------------------------------------------------------

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Appends one decimal digit to the parameter, clamping at the 32-bit signed limits.
    // A fresh digit starts a new number instead of extending the old one.
    function automatic logic signed [31:0] push_digit(input logic signed [31:0] acc,
                                                      input logic [7:0] c, input bit neg,
                                                      input bit fresh);
        longint v;
        int     dig;
        dig = c - CH_ZERO;
        v = fresh ? 64'sd0 : longint'(acc);
        if (neg) begin
            v = v * 10 - dig;
            if (v < ARG_MIN) v = ARG_MIN;
        end else begin
            v = v * 10 + dig;
            if (v > ARG_MAX) v = ARG_MAX;
        end
        return v[31:0];
    endfunction

    // Advances the body parser by one byte. Anything after the parameter is ignored.
    function automatic void parse_body_byte(input logic [7:0] c);
        bit dig;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        case (parse_state)
            SEEK_CMD: begin
                if (!is_space(c)) begin
                    cmd_char = c;
                    parse_state = AFTER_CMD;
                end
            end
            AFTER_CMD: begin
                if (!is_space(c)) begin
                    if (c == CH_PLUS) parse_state = SAW_PLUS;
                    else if (c == CH_MINUS) parse_state = SAW_MINUS;
                    else if (dig) begin
                        arg_value = push_digit(arg_value, c, 1'b0, 1'b1);
                        parse_state = POS_DIGITS;
                    end else parse_state = ARG_DONE;
                end
            end
            // A lone sign with no digit leaves the previous parameter in place.
            SAW_PLUS, SAW_MINUS: begin
                if (dig) begin
                    arg_value = push_digit(arg_value, c, parse_state == SAW_MINUS, 1'b1);
                    parse_state = (parse_state == SAW_MINUS) ? NEG_DIGITS : POS_DIGITS;
                end else parse_state = ARG_DONE;
            end
            POS_DIGITS, NEG_DIGITS: begin
                if (dig) arg_value = push_digit(arg_value, c, parse_state == NEG_DIGITS, 1'b0);
                else parse_state = ARG_DONE;
            end
            default: ;
        endcase
    endfunction

    // Feeds one accepted byte to the predictor. Only the end character of an open
    // packet yields a result, which is queued for the result monitor.
    function automatic void take_byte(input logic [7:0] c);
        frcr_pkg::t_result r;
        logic [63:0]       prod;
        if (!frame_open) begin
            if (c == cfg_start) begin
                frame_open = 1'b1;
                frame_len = 1;
                parse_state = SEEK_CMD;
            end
            return;
        end
        // Inside a packet the start character is just another body byte.
        if (c != cfg_end) begin
            if (frame_len < BUFFER_DEPTH) begin
                parse_body_byte(c);
                frame_len++;
            end
            return;
        end

        r = '0;
        r.status = frcr_pkg::ST_OK;
        if (frame_len >= BUFFER_DEPTH || parse_state == SEEK_CMD) begin
            // Overlong packet, or no command character at all: nothing runs.
            r.status = frcr_pkg::ST_MALFORMED;
        end else if (motor_running) begin
            // While running only a halt has any effect.
            if (cmd_char == frcr_pkg::CMD_HALT) begin
                motor_running = 1'b0;
                r.stop_run = 1'b1;
            end
        end else begin
            case (cmd_char)
                frcr_pkg::CMD_GO: begin
                    prod = ((64'(cfg_ppr) * 64'(speed_rpm)) / 64'd60) * 64'(down_time);
                    r.rotation_pulses = prod[47:0];
                    r.start_run = 1'b1;
                    motor_running = 1'b1;
                end
                frcr_pkg::CMD_TIME: begin
                    if (arg_value >= 0 && arg_value < int'(cfg_time_limit)) begin
                        down_time = arg_value[15:0];
                        session_time = down_time;
                        r.counter_load = 1'b1;
                        r.counter_value = down_time;
                    end else r.status = frcr_pkg::ST_TIME;
                end
                frcr_pkg::CMD_RELOAD, frcr_pkg::CMD_CONT: begin
                    down_time = session_time;
                    r.counter_load = 1'b1;
                    r.counter_value = down_time;
                end
                frcr_pkg::CMD_SPEED: begin
                    if (arg_value >= 0 && arg_value < int'(cfg_speed_limit))
                        speed_rpm = arg_value[15:0];
                    else r.status = frcr_pkg::ST_SPEED;
                end
                frcr_pkg::CMD_DUMP: r.dump_request = 1'b1;
                default: ;
            endcase
        end

        frame_open = 1'b0;
        frame_len = 0;
        parse_state = SEEK_CMD;

        r.command = cmd_char;
        r.argument = arg_value;
        r.running = motor_running;
        status_count[r.status]++;
        if (r.start_run) runs_started++;
        if (r.stop_run) runs_halted++;
        result_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Checking helpers
    // ------------------------------------------------------------------

    function automatic string describe(input frcr_pkg::t_result r);
        return $sformatf({"status=%0d cmd=%02h arg=%0d running=%0b start=%0b pulses=%0d ",
                          "stop=%0b load=%0b count=%0d dump=%0b"},
                         r.status, r.command, r.argument, r.running, r.start_run,
                         r.rotation_pulses, r.stop_run, r.counter_load, r.counter_value,
                         r.dump_request);
    endfunction

    function automatic string field_diffs(input frcr_pkg::t_result want,
                                          input frcr_pkg::t_result got);
        string s;
        s = "";
        if (got.status !== want.status) s = {s, " status"};
        if (got.command !== want.command) s = {s, " command"};
        if (got.argument !== want.argument) s = {s, " argument"};
        if (got.running !== want.running) s = {s, " running"};
        if (got.start_run !== want.start_run) s = {s, " start_run"};
        if (got.rotation_pulses !== want.rotation_pulses) s = {s, " rotation_pulses"};
        if (got.stop_run !== want.stop_run) s = {s, " stop_run"};
        if (got.counter_load !== want.counter_load) s = {s, " counter_load"};
        if (got.counter_value !== want.counter_value) s = {s, " counter_value"};
        if (got.dump_request !== want.dump_request) s = {s, " dump_request"};
        return s;
    endfunction

    // Only the first few failures are printed; the rest are just counted.
    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------

    // Offers bytes from byte_q. A byte stays on the bus until its transfer completes;
    // only then may the driver idle or move to the next byte. The predictor sees each
    // byte at the edge of its transfer.
    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                take_byte(rx_byte);
                bytes_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    in_valid <= 1'b1;
                    rx_byte <= byte_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------

    // Checks every result transfer against the oldest prediction, field by field,
    // and throttles ready at random or holds it off entirely during the pressure test.
    always @(posedge i_clk) begin : result_monitor
        frcr_pkg::t_result got;
        frcr_pkg::t_result want;
        string             bad;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                got.status          = o_status;
                got.command         = o_command;
                got.argument        = o_argument;
                got.running         = o_running;
                got.start_run       = o_start_run;
                got.rotation_pulses = o_rotation_pulses;
                got.stop_run        = o_stop_run;
                got.counter_load    = o_counter_load;
                got.counter_value   = o_counter_value;
                got.dump_request    = o_dump_request;
                results_seen++;
                if (result_q.size() == 0) begin
                    flag_error($sformatf("result with none expected: %s", describe(got)));
                end else begin
                    want = result_q.pop_front();
                    bad = field_diffs(want, got);
                    if (bad != "")
                        flag_error($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                                             results_seen, bad, describe(want), describe(got)));
                end
            end
            out_ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here in its own process. The sender keeps offering
    // bytes meanwhile, so the command queue fills and the input must stall.
    initial begin : receiver_hold_off
        wait (hold_arm);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Ends a hung run.
    initial begin : watchdog
        #(3_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            frcr_pkg::CFG_START_CHAR:  cfg_start = val[7:0];
            frcr_pkg::CFG_END_CHAR:    cfg_end = val[7:0];
            frcr_pkg::CFG_TIME_LIMIT:  cfg_time_limit = val;
            frcr_pkg::CFG_SPEED_LIMIT: cfg_speed_limit = val;
            frcr_pkg::CFG_PPR:         cfg_ppr = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] start_c, input logic [7:0] end_c,
                             input logic [15:0] max_t, input logic [15:0] max_s,
                             input logic [15:0] ppr);
        write_reg(frcr_pkg::CFG_START_CHAR, {8'd0, start_c});
        write_reg(frcr_pkg::CFG_END_CHAR, {8'd0, end_c});
        write_reg(frcr_pkg::CFG_TIME_LIMIT, max_t);
        write_reg(frcr_pkg::CFG_SPEED_LIMIT, max_s);
        write_reg(frcr_pkg::CFG_PPR, ppr);
        settings_used++;
    endtask

    // Queues a byte that belongs to a packet, counting it toward the phase budget.
    task automatic put(input logic [7:0] b);
        byte_q.push_back(b);
        framed_bytes++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic put_packet(input string body);
        put(cfg_start);
        put_text(body);
        put(cfg_end);
    endtask

    // Any byte but the end character, which would close the packet early.
    function automatic logic [7:0] rand_body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == cfg_end);
        return b;
    endfunction

    function automatic logic [7:0] rand_space();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
    endfunction

    // Decimal text aimed at the interesting values: small, around each limit,
    // anywhere in 16 bits, full 32 bits, and long enough to saturate.
    function automatic string number_text();
        int unsigned v;
        string       s;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 20);
            1: v = cfg_time_limit + $urandom_range(0, 2) - 1;
            2: v = cfg_speed_limit + $urandom_range(0, 2) - 1;
            3: v = $urandom_range(0, 65535);
            4: v = $urandom;
            default: begin
                s = "";
                repeat ($urandom_range(10, 14)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
                return s;
            end
        endcase
        return $sformatf("%0d", v);
    endfunction

    // A well-formed packet with random spacing, command, parameter form and trailing bytes.
    // One in twenty carries no command at all.
    task automatic random_packet();
        logic [7:0] cmd_list [7];
        int         k;
        cmd_list = '{frcr_pkg::CMD_GO, frcr_pkg::CMD_HALT, frcr_pkg::CMD_TIME,
                     frcr_pkg::CMD_SPEED, frcr_pkg::CMD_RELOAD, frcr_pkg::CMD_CONT,
                     frcr_pkg::CMD_DUMP};
        put(cfg_start);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(rand_space());
        if ($urandom_range(0, 19) != 0) begin
            k = $urandom_range(0, 9);
            put(k < 7 ? cmd_list[k] : rand_body_byte());
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put(rand_space());
            case ($urandom_range(0, 9))
                0, 1: ;
                2: put($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                3: begin
                    put(CH_MINUS);
                    put_text(number_text());
                end
                4: begin
                    put(CH_PLUS);
                    put_text(number_text());
                end
                default: put_text(number_text());
            endcase
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(rand_body_byte());
        end
        put(cfg_end);
    endtask

    // Mostly well-formed packets; the rest is line noise, packets cut short (which run
    // into the next one) and long packets near or past the buffer size.
    task automatic random_phase(input int budget);
        int roll;
        framed_bytes = 0;
        while (framed_bytes < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 86) begin
                random_packet();
            end else if (roll < 92) begin
                repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(0, 255)));
            end else if (roll < 97) begin
                put(cfg_start);
                repeat ($urandom_range(0, 5)) put(rand_body_byte());
            end else begin
                put(cfg_start);
                repeat ($urandom_range(54, 70)) put(rand_body_byte());
                put(cfg_end);
            end
        end
        random_packet();
    endtask

    // Lets every queued byte go through, closes a packet left open, and waits until all
    // predicted results are in plus a margin, so that the block is idle afterwards.
    task automatic settle();
        while (byte_q.size() != 0 || in_valid) @(negedge i_clk);
        if (frame_open) begin
            byte_q.push_back(cfg_end);
            while (byte_q.size() != 0 || in_valid) @(negedge i_clk);
        end
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        string long_body;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed packets under the reset configuration, light idling on both sides.
        sender_idle_pct = 11;
        recv_stall_pct  = 11;
        byte_q.push_back(cfg_end);              // end character outside a packet
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        put_packet("");                          // empty packet: no command
        put_packet(" \t\n\v\f\015 ");            // whitespace only: no command
        put_packet("s 500");
        put_packet("s1000");                     // speed at the limit
        put_packet("s-1");                       // negative speed
        put_packet("t 10");
        put_packet("t3600");                     // time at the limit
        put_packet("t+");                        // sign with no digit keeps the old value
        put_packet("t 7 junk");                  // bytes after the parameter are ignored
        put_packet("g");                         // starts a run with speed 500 and time 7
        put_packet("t5");                        // ignored while running
        put_packet("h");
        put_packet("h");                         // halt while idle does nothing
        put_packet("r");
        put_packet(" c ");
        put_packet("d");
        put_packet("s99999999999");              // saturates high
        put_packet("s -99999999999");            // saturates low
        put_packet("t-");
        put_packet("x 42");                      // unknown command
        put_packet("t<5");                       // start character inside a packet
        put(cfg_start);                          // extreme bytes as command and body
        put(8'hFF);
        put(8'h00);
        put(cfg_end);
        // Bodies of 62, 63 and 70 bytes: the first just fits, the others overflow.
        long_body = "d";
        repeat (61) long_body = {long_body, "1"};
        put_packet(long_body);
        long_body = {long_body, "2"};
        put_packet(long_body);
        long_body = {long_body, "3456789"};
        put_packet(long_body);
        settle();

        // High extremes; no idling, plus the long receiver hold-off.
        configure(8'h7B, 8'h7D, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_arm = 1'b1;
        random_phase(PHASE_BYTES);
        settle();

        // Low extremes: every time and speed is out of range. Sender idles half the time.
        configure(8'h00, 8'hFF, 16'h0000, 16'h0000, 16'h0001);
        sender_idle_pct = 49;
        recv_stall_pct  = 0;
        random_phase(PHASE_BYTES);
        settle();

        // Random limits; receiver stalls half the time.
        configure(8'h3C, 8'h3E, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                  16'($urandom_range(1, 65535)));
        sender_idle_pct = 0;
        recv_stall_pct  = 49;
        random_phase(PHASE_BYTES);
        settle();

        // Same character opens and closes a packet; light idling on both sides.
        configure(8'h23, 8'h23, 16'd3600, 16'd1000, 16'd200);
        sender_idle_pct = 11;
        recv_stall_pct  = 11;
        random_phase(PHASE_BYTES);
        settle();

        // Back to the reset values, sender idling again.
        configure(8'd60, 8'd62, 16'd3600, 16'd1000, 16'd200);
        sender_idle_pct = 49;
        recv_stall_pct  = 0;
        random_phase(PHASE_BYTES);
        settle();

        $display("Run covered %0d byte transfers and %0d result transfers over %0d settings.",
                 bytes_accepted, results_seen, settings_used);
        $display("Statuses ok/time/speed/malformed: %0d/%0d/%0d/%0d; runs started %0d, halted %0d.",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 runs_started, runs_halted);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/frcr_pkg.sv
sv/frcr_front.sv
sv/frcr_queue.sv
sv/frcr_back.sv
sv/framed_command_receiver_unit.sv
verif/tb_framed_command_receiver_unit.sv
